>>> design/bsc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
// No dependencies.
package bsc_pkg;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic [2:0] REG_AC1_AC2  = 3'd0;
  localparam logic [2:0] REG_AC3_AC4  = 3'd1;
  localparam logic [2:0] REG_AC5_AC6  = 3'd2;
  localparam logic [2:0] REG_B1_B2    = 3'd3;
  localparam logic [2:0] REG_MC_MD    = 3'd4;
  localparam logic [2:0] REG_OSS      = 3'd5;

  localparam logic [31:0] C_B6_OFS    = 32'd4000;
  localparam logic [31:0] C_P_X1      = 32'd3038;
  localparam logic [31:0] C_P_X2      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] C_P_OFS     = 32'd3791;
  localparam logic [31:0] C_B4_OFS    = 32'd32768;
  localparam logic [31:0] C_B7_SCALE  = 32'd50000;
  localparam logic [31:0] C_P_MAX     = 32'd1048575;

  typedef struct packed {
    logic        vld;
    logic        dz;
    logic        bz;
    logic        neg;
    logic        post;
    logic [23:0] raw;
    logic [15:0] tsat;
    logic [31:0] p;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } item_t;

endpackage

>>> design/bsc_div_cell.sv
// One restoring division step: shifts one numerator bit into the remainder.
// Depends on bsc_pkg.
module bsc_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  bsc_pkg::item_t d_in,
  output bsc_pkg::item_t d_out
);
  import bsc_pkg::*;

  item_t       q_r;
  item_t       q_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    trial = {d_in.rem, d_in.quo[31]};
    diff  = trial - {1'b0, d_in.dvs};
    q_nxt = d_in;
    if (!diff[32]) begin
      q_nxt.rem = diff[31:0];
      q_nxt.quo = {d_in.quo[30:0], 1'b1};
    end else begin
      q_nxt.rem = trial[31:0];
      q_nxt.quo = {d_in.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

>>> design/bsc_div_chain.sv
// Row of division cells, one quotient bit per cell, 32 cells deep.
// Depends on bsc_pkg and bsc_div_cell.
module bsc_div_chain (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  bsc_pkg::item_t d_in,
  output bsc_pkg::item_t d_out
);
  import bsc_pkg::*;

  item_t link [DIV_STEPS+1];

  assign link[0] = d_in;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    bsc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (link[g]),
      .d_out (link[g+1])
    );
  end

  assign d_out = link[DIV_STEPS];

endmodule

>>> design/barometric_sensor_compensation.sv
// Top level: calibration registers, arithmetic stages and two divider chains.
// Depends on bsc_pkg, bsc_div_chain.
//
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, raw_temperature/pressure | sink
//  out     | out_valid/out_ready, temperature, pressure, status | source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | sink
//
// One item per cycle while the output is not stalled; 16 arithmetic stages, two chains
// of 32 division cells, one output register.
// Reset clears all valid bits, calibration words to 0 and oversampling to 3.
// A stalled output holds the pipe only once the last stage is occupied.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_raw_temperature,
  input  logic [23:0] in_raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_temperature_tenths,
  output logic [19:0] out_pressure_pa,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bsc_pkg::*;

  logic [31:0] cal0_r, cal1_r, cal2_r, cal3_r, cal4_r;
  logic [1:0]  oss_r;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  item_t st_r   [16];
  item_t st_nxt [16];
  item_t diva_out, divb_out;
  logic  en, ld;

  logic               out_valid_r;
  logic signed [15:0] out_t_r;
  logic [19:0]        out_p_r;
  logic               out_s_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      cal3_r <= '0;
      cal4_r <= '0;
      oss_r  <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AC1_AC2: cal0_r <= cfg_data;
        REG_AC3_AC4: cal1_r <= cfg_data;
        REG_AC5_AC6: cal2_r <= cfg_data;
        REG_B1_B2:   cal3_r <= cfg_data;
        REG_MC_MD:   cal4_r <= cfg_data;
        REG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign ac1 = {{16{cal0_r[31]}}, cal0_r[31:16]};
  assign ac2 = {{16{cal0_r[15]}}, cal0_r[15:0]};
  assign ac3 = {{16{cal1_r[31]}}, cal1_r[31:16]};
  assign ac4 = {16'b0, cal1_r[15:0]};
  assign ac5 = {16'b0, cal2_r[31:16]};
  assign ac6 = {16'b0, cal2_r[15:0]};
  assign b1  = {{16{cal3_r[31]}}, cal3_r[31:16]};
  assign b2  = {{16{cal3_r[15]}}, cal3_r[15:0]};
  assign mc  = {{16{cal4_r[31]}}, cal4_r[31:16]};
  assign md  = {{16{cal4_r[15]}}, cal4_r[15:0]};

  assign ld       = !out_valid_r || out_ready;
  assign en       = !st_r[15].vld || ld;
  assign in_ready = en;

  // temperature: X1 product
  always_comb begin
    st_nxt[0]     = '0;
    st_nxt[0].vld = in_valid;
    st_nxt[0].raw = in_raw_pressure;
    st_nxt[0].a   = ({16'b0, in_raw_temperature} - ac6) * ac5;
  end

  // divider setup for MC << 11 / (X1 + MD)
  always_comb begin
    logic [31:0] x1, den, num;
    x1  = 32'($signed(st_r[0].a) >>> 15);
    den = x1 + md;
    num = mc << 11;
    st_nxt[1]     = st_r[0];
    st_nxt[1].b   = x1;
    st_nxt[1].dz  = (den == 32'd0);
    st_nxt[1].neg = num[31] ^ den[31];
    st_nxt[1].rem = '0;
    st_nxt[1].quo = num[31] ? (32'd0 - num) : num;
    st_nxt[1].dvs = den[31] ? (32'd0 - den) : den;
  end

  // B5, temperature, B6
  always_comb begin
    logic [31:0] q, b5, tt;
    q  = diva_out.neg ? (32'd0 - diva_out.quo) : diva_out.quo;
    b5 = diva_out.b + q;
    tt = 32'($signed(b5 + 32'd8) >>> 4);
    st_nxt[2] = diva_out;
    if ($signed(tt) > 32'sd32767) begin
      st_nxt[2].tsat = 16'h7FFF;
    end else if ($signed(tt) < -32'sd32768) begin
      st_nxt[2].tsat = 16'h8000;
    end else begin
      st_nxt[2].tsat = tt[15:0];
    end
    st_nxt[2].b = b5 - C_B6_OFS;
  end

  always_comb begin
    st_nxt[3]   = st_r[2];
    st_nxt[3].a = st_r[2].b * st_r[2].b;
    st_nxt[3].c = ac3 * st_r[2].b;
    st_nxt[3].b = ac2 * st_r[2].b;
  end

  always_comb begin
    st_nxt[4]   = st_r[3];
    st_nxt[4].a = 32'($signed(st_r[3].a) >>> 12);
    st_nxt[4].b = 32'($signed(st_r[3].b) >>> 11);
    st_nxt[4].c = 32'($signed(st_r[3].c) >>> 13);
  end

  always_comb begin
    st_nxt[5]     = st_r[4];
    st_nxt[5].rem = b2 * st_r[4].a;
    st_nxt[5].dvs = b1 * st_r[4].a;
  end

  // X3 for B3, and X3 + 32768 for B4
  always_comb begin
    logic [31:0] s;
    s = st_r[5].c + 32'($signed(st_r[5].dvs) >>> 16) + 32'd2;
    st_nxt[6]   = st_r[5];
    st_nxt[6].a = 32'($signed(st_r[5].rem) >>> 11) + st_r[5].b;
    st_nxt[6].c = 32'($signed(s) >>> 2) + C_B4_OFS;
  end

  always_comb begin
    st_nxt[7]   = st_r[6];
    st_nxt[7].b = (((ac1 << 2) + st_r[6].a) << oss_r) + 32'd2;
    st_nxt[7].c = ac4 * st_r[6].c;
  end

  // B3 (truncate toward zero), B4, UP
  always_comb begin
    logic [31:0] v, m, b4;
    logic [3:0]  sh;
    v  = st_r[7].b;
    m  = 32'd0 - v;
    b4 = st_r[7].c >> 15;
    sh = 4'd8 - {2'b0, oss_r};
    st_nxt[8]     = st_r[7];
    st_nxt[8].b   = v[31] ? (32'd0 - (m >> 2)) : (v >> 2);
    st_nxt[8].a   = b4;
    st_nxt[8].bz  = (b4 == 32'd0);
    st_nxt[8].rem = {8'b0, st_r[7].raw} >> sh;
  end

  always_comb begin
    st_nxt[9]   = st_r[8];
    st_nxt[9].b = st_r[8].rem - st_r[8].b;
  end

  always_comb begin
    st_nxt[10]   = st_r[9];
    st_nxt[10].c = st_r[9].b * (C_B7_SCALE >> oss_r);
  end

  // divider setup for the two-branch pressure quotient
  always_comb begin
    st_nxt[11]      = st_r[10];
    st_nxt[11].post = st_r[10].c[31];
    st_nxt[11].quo  = st_r[10].c[31] ? st_r[10].c : {st_r[10].c[30:0], 1'b0};
    st_nxt[11].dvs  = st_r[10].a;
    st_nxt[11].rem  = '0;
  end

  always_comb begin
    logic [31:0] p;
    p = divb_out.post ? {divb_out.quo[30:0], 1'b0} : divb_out.quo;
    st_nxt[12]   = divb_out;
    st_nxt[12].p = p;
    st_nxt[12].a = 32'($signed(p) >>> 8);
  end

  always_comb begin
    st_nxt[13]   = st_r[12];
    st_nxt[13].b = st_r[12].a * st_r[12].a;
    st_nxt[13].c = st_r[12].p * C_P_X2;
  end

  always_comb begin
    st_nxt[14]   = st_r[13];
    st_nxt[14].b = st_r[13].b * C_P_X1;
    st_nxt[14].c = 32'($signed(st_r[13].c) >>> 16);
  end

  always_comb begin
    logic [31:0] s;
    s = 32'($signed(st_r[14].b) >>> 16) + st_r[14].c + C_P_OFS;
    st_nxt[15]   = st_r[14];
    st_nxt[15].p = st_r[14].p + 32'($signed(s) >>> 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        st_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < 16; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  bsc_div_chain u_div_t (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (st_r[1]),
    .d_out (diva_out)
  );

  bsc_div_chain u_div_p (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (st_r[11]),
    .d_out (divb_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= st_r[15].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      if (st_r[15].dz) begin
        out_t_r <= '0;
        out_p_r <= '0;
        out_s_r <= 1'b1;
      end else if (st_r[15].bz) begin
        out_t_r <= st_r[15].tsat;
        out_p_r <= '0;
        out_s_r <= 1'b1;
      end else begin
        out_t_r <= st_r[15].tsat;
        out_s_r <= 1'b0;
        if (st_r[15].p[31]) begin
          out_p_r <= '0;
        end else if (st_r[15].p > C_P_MAX) begin
          out_p_r <= C_P_MAX[19:0];
        end else begin
          out_p_r <= st_r[15].p[19:0];
        end
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = out_t_r;
  assign out_pressure_pa        = out_p_r;
  assign out_status             = out_s_r;

endmodule

>>> dv/tb_barometric_sensor_compensation.sv
// Self-checking testbench for barometric_sensor_compensation: random and directed
// raw readings under several calibration sets, with results predicted in-line.
// Depends on bsc_pkg and the barometric_sensor_compensation RTL.
`timescale 1ns / 1ps

module tb_barometric_sensor_compensation;
  import bsc_pkg::*;

  typedef struct {
    logic [15:0] ut;
    logic [23:0] raw;
  } reading_t;

  typedef struct {
    logic [15:0] temp;
    logic [19:0] pres;
    logic        status;
  } comp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [15:0] in_raw_temperature;
  logic [23:0] in_raw_pressure;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_temperature_tenths;
  logic [19:0] out_pressure_pa;
  logic out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] cal [0:5];
  reading_t pending_q[$];
  comp_t comp_q[$];
  bit calm;
  int errors;

  barometric_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_temperature(in_raw_temperature), .in_raw_pressure(in_raw_pressure),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temperature_tenths(out_temperature_tenths),
    .out_pressure_pa(out_pressure_pa), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, tv;
    int unsigned oss;
    oss = cal[REG_OSS][1:0];
    ac1 = sx16(cal[REG_AC1_AC2][31:16]);
    ac2 = sx16(cal[REG_AC1_AC2][15:0]);
    ac3 = sx16(cal[REG_AC3_AC4][31:16]);
    ac4 = {16'd0, cal[REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal[REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal[REG_AC5_AC6][15:0]};
    b1 = sx16(cal[REG_B1_B2][31:16]);
    b2 = sx16(cal[REG_B1_B2][15:0]);
    mc = sx16(cal[REG_MC_MD][31:16]);
    md = sx16(cal[REG_MC_MD][15:0]);
    ut = {16'd0, r.ut};
    up = {8'd0, r.raw} >> (8 - oss);
    c.temp = '0;
    c.pres = '0;
    c.status = 1'b1;
    x1 = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return c;
    x2 = sdiv(mc << 11, den);
    b5 = x1 + x2;
    tv = asr(b5 + 32'd8, 4);
    if ($signed(tv) > 32767) tv = 32'd32767;
    if ($signed(tv) < -32768) tv = 32'hFFFF_8000;
    c.temp = tv[15:0];
    b6 = b5 - C_B6_OFS;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sdiv((((ac1 * 32'd4) + x3) << oss) + 32'd2, 32'd4);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + C_B4_OFS)) >> 15;
    if (b4 == 0) return c;
    b7 = (up - b3) * (C_B7_SCALE >> oss);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = asr(p, 8);
    x1 = x1 * x1;
    x1 = asr(x1 * C_P_X1, 16);
    x2 = asr(p * C_P_X2, 16);
    p = p + asr(x1 + x2 + C_P_OFS, 4);
    if ($signed(p) < 0) p = 32'd0;
    if ($signed(p) > $signed(C_P_MAX)) p = C_P_MAX;
    c.pres = p[19:0];
    c.status = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    reading_t r;
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        r.ut = in_raw_temperature;
        r.raw = in_raw_pressure;
        comp_q.push_back(compensate(r));
      end
      if (!in_valid || fire) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          r = pending_q.pop_front();
          in_valid <= 1'b1;
          in_raw_temperature <= r.ut;
          in_raw_pressure <= r.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    comp_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (comp_q.size() == 0) begin
          $error("result with no expectation");
          errors++;
        end else begin
          e = comp_q.pop_front();
          if (out_temperature_tenths !== e.temp) begin
            $error("temperature_tenths exp %0d got %0d", $signed(e.temp),
                   out_temperature_tenths);
            errors++;
          end
          if (out_pressure_pa !== e.pres) begin
            $error("pressure_pa exp %0d got %0d", e.pres, out_pressure_pa);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OSS) cal[idx] = {30'd0, val[1:0]};
    else if (idx < REG_OSS) cal[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || comp_q.size() > 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic add(logic [15:0] ut, logic [23:0] raw);
    reading_t r;
    r.ut = ut;
    r.raw = raw;
    pending_q.push_back(r);
  endtask

  function automatic logic [15:0] jit(logic [15:0] base);
    return base + 16'($urandom_range(63)) - 16'd32;
  endfunction

  task automatic load_cal(int kind, logic [31:0] oss_word);
    logic [31:0] w [0:4];
    case (kind)
      0: begin
        w[0] = {16'd408, 16'hFFB8};
        w[1] = {16'hC7D1, 16'd32741};
        w[2] = {16'd32757, 16'd23153};
        w[3] = {16'd6190, 16'd4};
        w[4] = {16'hDDF9, 16'd2868};
      end
      1: begin
        w[0] = {jit(16'd408), jit(16'hFFB8)};
        w[1] = {jit(16'hC7D1), jit(16'd32741)};
        w[2] = {jit(16'd32757), jit(16'd23153)};
        w[3] = {jit(16'd6190), jit(16'd4)};
        w[4] = {jit(16'hDDF9), jit(16'd2868)};
      end
      2: for (int i = 0; i < 5; i++) w[i] = $urandom;
      3: for (int i = 0; i < 5; i++) w[i] = 32'hFFFF_FFFF;
      4: for (int i = 0; i < 5; i++) w[i] = 32'h8000_8000;
      default: for (int i = 0; i < 5; i++) w[i] = 32'h7FFF_7FFF;
    endcase
    write_reg(REG_AC1_AC2, w[0]);
    write_reg(REG_AC3_AC4, w[1]);
    write_reg(REG_AC5_AC6, w[2]);
    write_reg(REG_B1_B2, w[3]);
    write_reg(REG_MC_MD, w[4]);
    write_reg(REG_OSS, oss_word);
  endtask

  initial begin
    int kind;
    errors = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 5; i++) cal[i] = '0;
    cal[REG_OSS] = 32'd3;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: temperature divisor is zero
    add(16'h0000, 24'h000000);
    add(16'hFFFF, 24'hFFFFFF);
    add(16'h5555, 24'hAAAAAA);
    drain();

    load_cal(0, 32'd0);
    add(16'd27898, {16'd23843, 8'h00});
    add(16'h0000, 24'h000000);
    add(16'hFFFF, 24'hFFFFFF);
    add(16'hFFFF, 24'h000000);
    add(16'h0000, 24'hFFFFFF);
    add(16'hAAAA, 24'h555555);
    drain();

    // ac4 of zero forces the pressure divisor to zero
    write_reg(REG_AC3_AC4, 32'hC7D1_0000);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    add(16'd27898, 24'h5D2300);
    add(16'd30000, 24'hFFFFFF);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      kind = (ph < 4) ? 0 : (ph < 9) ? ($urandom_range(3) == 0 ? 2 : 1) : ph - 6;
      load_cal(kind, {30'($urandom_range(32'h3FFF_FFFF)), ph[1:0]});
      if (ph == 7) write_reg(3'($urandom_range(7, 6)), $urandom);
      calm = (ph == 5);
      for (int n = 0; n < ((ph < 9) ? 110 : 25); n++) begin
        if ($urandom_range(3) != 0)
          add(16'($urandom_range(36000, 20000)), 24'($urandom_range(24'hD00000, 24'h300000)));
        else
          add(16'($urandom), 24'($urandom));
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) $display("barometric_sensor_compensation: match");
    else $display("barometric_sensor_compensation: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("barometric_sensor_compensation: mismatch");
    $finish;
  end

endmodule

>>> barometric_sensor_compensation.f
design/bsc_pkg.sv
design/bsc_div_cell.sv
design/bsc_div_chain.sv
design/barometric_sensor_compensation.sv
dv/tb_barometric_sensor_compensation.sv
